/* rtl/number_literal_recognizer_assert.svh */
// assertion macros for the number literal recognizer
`ifndef NUMBER_LITERAL_RECOGNIZER_ASSERT_SVH
`define NUMBER_LITERAL_RECOGNIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define NLR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nlr: same-cycle check failed");
`define NLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nlr: next-cycle check failed");
`else
`define NLR_ASSERT_IMP(label, ante, cons)
`define NLR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/nlr_pkg.sv */
`default_nettype none

package nlr_pkg;

  localparam int SPELL_COUNT = 10;
  localparam int SPELL_MAX   = 10;

  localparam logic [3:0] POS_SAT = 4'd11;

  localparam logic [SPELL_COUNT-1:0] ALIVE_ALL = '1;
  localparam logic [SPELL_COUNT-1:0] INF_SET   = 10'h00F;
  localparam logic [SPELL_COUNT-1:0] NAN_SET   = 10'h3F0;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_I  = 8'h69;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_L  = 8'h6C;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_UP_L  = 8'h4C;
  localparam logic [7:0] CH_UP_U  = 8'h55;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_STOP  = 8'hFF;

  // inff, -inff, inf, -inf, nanf, -nanf, -nan(ind)f, nan, -nan, -nan(ind)
  localparam logic [7:0] SPELL_TEXT [SPELL_COUNT][SPELL_MAX] = '{
    '{8'h69, 8'h6E, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2D, 8'h69, 8'h6E, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h6E, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2D, 8'h69, 8'h6E, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6E, 8'h61, 8'h6E, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2D, 8'h6E, 8'h61, 8'h6E, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2D, 8'h6E, 8'h61, 8'h6E, 8'h28, 8'h69, 8'h6E, 8'h64, 8'h29, 8'h66},
    '{8'h6E, 8'h61, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2D, 8'h6E, 8'h61, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2D, 8'h6E, 8'h61, 8'h6E, 8'h28, 8'h69, 8'h6E, 8'h64, 8'h29, 8'h00}
  };

  localparam logic [3:0] SPELL_LEN [SPELL_COUNT] = '{
    4'd4, 4'd5, 4'd3, 4'd4, 4'd4, 4'd5, 4'd10, 4'd3, 4'd4, 4'd9
  };

  typedef enum logic [9:0] {
    PH_BEGIN   = 10'b00_0000_0001,
    PH_INT     = 10'b00_0000_0010,
    PH_FRAC    = 10'b00_0000_0100,
    PH_EXPSIGN = 10'b00_0000_1000,
    PH_EXP     = 10'b00_0001_0000,
    PH_SUFFIX  = 10'b00_0010_0000,
    PH_INFWAIT = 10'b00_0100_0000,
    PH_NANWAIT = 10'b00_1000_0000,
    PH_YES     = 10'b01_0000_0000,
    PH_NO      = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } nlr_in_t;

  typedef struct packed {
    logic is_numeric;
  } nlr_out_t;

  typedef struct packed {
    logic       fire;
    logic       end_mark;
    logic [7:0] ch;
  } nlr_step_t;

endpackage

`default_nettype wire

/* rtl/nlr_chan_if.sv */
`default_nettype none

interface nlr_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/nlr_scan.sv */
`default_nettype none

module nlr_scan
  import nlr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire nlr_step_t step,
  output logic           is_numeric
);

  phase_t                 phase, phase_next;
  logic                   digit_seen, digit_seen_next;
  logic [3:0]             char_position, char_position_next;
  logic [SPELL_COUNT-1:0] literal_alive, literal_alive_next;

  logic [SPELL_COUNT-1:0] spell_keep;
  logic [SPELL_COUNT-1:0] spell_hit;
  logic                   match_inf, match_nan;
  logic                   is_dig, is_int_sfx;

  always_comb begin
    for (int k = 0; k < SPELL_COUNT; k++) begin
      spell_keep[k] = (char_position < SPELL_LEN[k]) ?
                      (SPELL_TEXT[k][char_position] == step.ch) : 1'b0;
      spell_hit[k]  = literal_alive[k] && (SPELL_LEN[k] == char_position);
    end
  end

  assign match_inf  = |(spell_hit & INF_SET);
  assign match_nan  = |(spell_hit & NAN_SET);
  assign is_dig     = (step.ch >= CH_ZERO) && (step.ch <= CH_NINE);
  assign is_int_sfx = (step.ch == CH_LO_L) || (step.ch == CH_LO_U) ||
                      (step.ch == CH_UP_L) || (step.ch == CH_UP_U) ||
                      (step.ch == CH_LO_P);

  always_comb begin
    case (phase)
      PH_INT:     is_numeric = digit_seen;
      PH_FRAC:    is_numeric = 1'b1;
      PH_EXP:     is_numeric = 1'b1;
      PH_SUFFIX:  is_numeric = 1'b1;
      PH_INFWAIT: is_numeric = match_inf;
      PH_NANWAIT: is_numeric = match_nan;
      PH_YES:     is_numeric = 1'b1;
      default:    is_numeric = 1'b0;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    digit_seen_next    = digit_seen;
    char_position_next = char_position;
    literal_alive_next = literal_alive;
    if (step.fire) begin
      if (step.end_mark) begin
        phase_next         = PH_BEGIN;
        digit_seen_next    = 1'b0;
        char_position_next = '0;
        literal_alive_next = ALIVE_ALL;
      end else if (phase != PH_YES && phase != PH_NO) begin
        literal_alive_next = literal_alive & spell_keep;
        if (char_position < POS_SAT) begin
          char_position_next = char_position + 4'd1;
        end
        case (phase)
          PH_BEGIN: begin
            if (is_dig) begin
              digit_seen_next = 1'b1;
              phase_next      = PH_INT;
            end else if (step.ch == CH_MINUS) begin
              phase_next = PH_INT;
            end else if (step.ch == CH_LO_I) begin
              phase_next = PH_INFWAIT;
            end else if (step.ch == CH_LO_N) begin
              phase_next = PH_NANWAIT;
            end else begin
              phase_next = PH_NO;
            end
          end
          PH_INT: begin
            if (is_dig) begin
              digit_seen_next = 1'b1;
            end else if (step.ch == CH_LO_I) begin
              phase_next = PH_INFWAIT;
            end else if (step.ch == CH_LO_N) begin
              phase_next = PH_NANWAIT;
            end else if (step.ch == CH_POINT) begin
              phase_next = PH_FRAC;
            end else if (is_int_sfx || step.ch == CH_LO_F) begin
              phase_next = PH_SUFFIX;
            end else if (step.ch == CH_STOP) begin
              phase_next = digit_seen ? PH_YES : PH_NO;
            end else begin
              phase_next = PH_NO;
            end
          end
          PH_FRAC: begin
            if (is_dig) begin
              phase_next = PH_FRAC;
            end else if (step.ch == CH_LO_E) begin
              phase_next = PH_EXPSIGN;
            end else if (step.ch == CH_LO_F) begin
              phase_next = PH_SUFFIX;
            end else if (step.ch == CH_STOP) begin
              phase_next = PH_YES;
            end else begin
              phase_next = PH_NO;
            end
          end
          PH_EXPSIGN: begin
            phase_next = (step.ch == CH_PLUS || step.ch == CH_MINUS) ? PH_EXP : PH_NO;
          end
          PH_EXP: begin
            if (is_dig) begin
              phase_next = PH_EXP;
            end else if (is_int_sfx || step.ch == CH_LO_F) begin
              phase_next = PH_SUFFIX;
            end else if (step.ch == CH_STOP) begin
              phase_next = PH_YES;
            end else begin
              phase_next = PH_NO;
            end
          end
          PH_INFWAIT: phase_next = PH_INFWAIT;
          PH_NANWAIT: phase_next = PH_NANWAIT;
          default:    phase_next = PH_NO;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_BEGIN;
      digit_seen    <= 1'b0;
      char_position <= '0;
      literal_alive <= ALIVE_ALL;
    end else begin
      phase         <= phase_next;
      digit_seen    <= digit_seen_next;
      char_position <= char_position_next;
      literal_alive <= literal_alive_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/number_literal_recognizer.sv */
// channel   role    word fields               meaning
// token     sink    ch[7:0], end_mark         one byte of a token, or its end
// verdict   source  is_numeric                one flag for each end word
//
// one word is accepted every cycle except while an end word waits in the input register
// the scan state advances one byte per cycle between the input and result registers
// an end word waits in the input register only while the result register is still full
// synchronous reset empties both registers and returns the scan to its begin state
`default_nettype none

module number_literal_recognizer
  import nlr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  nlr_chan_if.sink    token,
  nlr_chan_if.source  verdict
);

  `include "number_literal_recognizer_assert.svh"

  logic      s1_valid;
  nlr_in_t   s1_word;
  logic      out_valid;
  nlr_out_t  out_word;

  logic      out_free;
  logic      s1_fire;
  logic      token_fire;
  nlr_step_t step;
  logic      scan_result;

  assign out_free    = !out_valid || verdict.ready;
  assign s1_fire     = s1_valid && (!s1_word.end_mark || out_free);
  assign token.ready = !s1_valid || s1_fire;
  assign token_fire  = token.valid && token.ready;

  assign step.fire     = s1_fire;
  assign step.end_mark = s1_word.end_mark;
  assign step.ch       = s1_word.ch;

  nlr_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .is_numeric (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (token_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (token_fire) begin
      s1_word <= token.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_word.end_mark) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_word.end_mark) begin
      out_word.is_numeric <= scan_result;
    end
  end

  assign verdict.valid = out_valid;
  assign verdict.data  = out_word;

  `NLR_ASSERT_NEXT(a_end_loads_result, s1_fire && s1_word.end_mark, verdict.valid)
  `NLR_ASSERT_IMP(a_byte_never_waits, s1_valid && !s1_word.end_mark, s1_fire)
  `NLR_ASSERT_IMP(a_stall_cause, !token.ready, s1_valid && s1_word.end_mark && !out_free)

endmodule

`default_nettype wire

/* verif/nlr_verdict_check.sv */
`timescale 1ns / 1ps

module nlr_verdict_check
  import nlr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     token_valid,
  input  logic     token_ready,
  input  nlr_in_t  token_word,
  input  logic     verdict_valid,
  input  logic     verdict_ready,
  input  nlr_out_t verdict_word,
  output int       pending,
  output int       errors,
  output int       flags_checked,
  output int       numeric_seen
);

  phase_t                 scan_phase;
  logic                   digit_seen;
  logic [3:0]             char_pos;
  logic [SPELL_COUNT-1:0] alive;
  logic                   flag_q[$];
  logic                   wanted;

  initial begin
    errors = 0;
    flags_checked = 0;
    numeric_seen = 0;
    pending = 0;
  end

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic sfx_letter(logic [7:0] c);
    return c inside {CH_LO_L, CH_LO_U, CH_UP_L, CH_UP_U, CH_LO_P};
  endfunction

  function automatic logic spelled(logic [SPELL_COUNT-1:0] set);
    for (int k = 0; k < SPELL_COUNT; k++) begin
      if (set[k] && alive[k] && SPELL_LEN[k] == char_pos) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic end_flag();
    case (scan_phase)
      PH_INT:     return digit_seen;
      PH_FRAC:    return 1'b1;
      PH_EXP:     return 1'b1;
      PH_SUFFIX:  return 1'b1;
      PH_INFWAIT: return spelled(INF_SET);
      PH_NANWAIT: return spelled(NAN_SET);
      PH_YES:     return 1'b1;
      default:    return 1'b0;
    endcase
  endfunction

  task automatic scan_clear();
    scan_phase = PH_BEGIN;
    digit_seen = 1'b0;
    char_pos   = '0;
    alive      = ALIVE_ALL;
  endtask

  task automatic scan_byte(logic [7:0] c);
    logic keep;
    if (scan_phase == PH_YES || scan_phase == PH_NO) return;
    for (int k = 0; k < SPELL_COUNT; k++) begin
      keep = 1'b0;
      if (char_pos < SPELL_LEN[k]) keep = SPELL_TEXT[k][char_pos] == c;
      if (!keep) alive[k] = 1'b0;
    end
    if (char_pos < POS_SAT) char_pos = char_pos + 4'd1;
    case (scan_phase)
      PH_BEGIN: begin
        if (is_digit(c)) begin
          digit_seen = 1'b1;
          scan_phase = PH_INT;
        end else if (c == CH_MINUS) scan_phase = PH_INT;
        else if (c == CH_LO_I) scan_phase = PH_INFWAIT;
        else if (c == CH_LO_N) scan_phase = PH_NANWAIT;
        else scan_phase = PH_NO;
      end
      PH_INT: begin
        if (is_digit(c)) digit_seen = 1'b1;
        else if (c == CH_LO_I) scan_phase = PH_INFWAIT;
        else if (c == CH_LO_N) scan_phase = PH_NANWAIT;
        else if (c == CH_POINT) scan_phase = PH_FRAC;
        else if (sfx_letter(c) || c == CH_LO_F) scan_phase = PH_SUFFIX;
        else if (c == CH_STOP) scan_phase = digit_seen ? PH_YES : PH_NO;
        else scan_phase = PH_NO;
      end
      PH_FRAC: begin
        if (is_digit(c)) scan_phase = PH_FRAC;
        else if (c == CH_LO_E) scan_phase = PH_EXPSIGN;
        else if (c == CH_LO_F) scan_phase = PH_SUFFIX;
        else if (c == CH_STOP) scan_phase = PH_YES;
        else scan_phase = PH_NO;
      end
      PH_EXPSIGN: begin
        scan_phase = (c == CH_PLUS || c == CH_MINUS) ? PH_EXP : PH_NO;
      end
      PH_EXP: begin
        if (is_digit(c)) scan_phase = PH_EXP;
        else if (sfx_letter(c) || c == CH_LO_F) scan_phase = PH_SUFFIX;
        else if (c == CH_STOP) scan_phase = PH_YES;
        else scan_phase = PH_NO;
      end
      PH_SUFFIX: scan_phase = PH_NO;
      PH_INFWAIT, PH_NANWAIT: scan_phase = scan_phase;
      default: scan_phase = PH_NO;
    endcase
  endtask

  task automatic report(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_clear();
      flag_q.delete();
    end else begin
      if (verdict_valid && verdict_ready) begin
        if (flag_q.size() == 0) begin
          report($sformatf("flag %b with no end word waiting", verdict_word.is_numeric));
        end else begin
          wanted = flag_q.pop_front();
          flags_checked++;
          if (wanted) numeric_seen++;
          if (verdict_word.is_numeric !== wanted)
            report($sformatf("is_numeric %b, predicted %b", verdict_word.is_numeric, wanted));
        end
      end
      if (token_valid && token_ready) begin
        if (token_word.end_mark) begin
          flag_q = {flag_q, end_flag()};
          scan_clear();
        end else begin
          scan_byte(token_word.ch);
        end
      end
    end
    pending <= flag_q.size();
  end

endmodule

/* verif/number_literal_recognizer_tb.sv */
`timescale 1ns / 1ps

module number_literal_recognizer_tb;
  import nlr_pkg::*;

  localparam int WORD_TARGET  = 900;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst;

  nlr_chan_if #(.T(nlr_in_t))  token_if ();
  nlr_chan_if #(.T(nlr_out_t)) verdict_if ();

  number_literal_recognizer dut (
    .clk     (clk),
    .rst     (rst),
    .token   (token_if),
    .verdict (verdict_if)
  );

  int pending;
  int errors;
  int flags_checked;
  int numeric_seen;

  nlr_verdict_check u_check (
    .clk           (clk),
    .rst           (rst),
    .token_valid   (token_if.valid),
    .token_ready   (token_if.ready),
    .token_word    (token_if.data),
    .verdict_valid (verdict_if.valid),
    .verdict_ready (verdict_if.ready),
    .verdict_word  (verdict_if.data),
    .pending       (pending),
    .errors        (errors),
    .flags_checked (flags_checked),
    .numeric_seen  (numeric_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic       no_idle = 1'b1;
  int         hold_req = 0;
  int         hold_done = 0;
  int         words_sent = 0;
  int         tokens_sent = 0;
  int         drains = 0;
  int         idle_cycles = 0;
  logic [7:0] tok[$];

  string directed_tokens[] = '{
    "", "0", "9", "-", "-.", "-f", "1.e+", "1.e", "-12.50e-07f", "7L", "42u1",
    "\377", "1\377", "-\377", "1.e\377", "1.5e+3\377", "3f\377", "inf", "-inff",
    "nan", "-nan(ind)f", "-nan(ind)", "nanx", "in\377", "8.f", "3p", "1.e+5L"
  };

  logic [7:0] odd_bytes[] = '{
    CH_MINUS, CH_PLUS, CH_POINT, CH_ZERO, CH_NINE, CH_LO_E, CH_LO_F, CH_LO_L, CH_LO_U,
    CH_UP_L, CH_UP_U, CH_LO_P, CH_LO_I, CH_LO_N, 8'h61, 8'h28, 8'h29, 8'h64, CH_STOP
  };

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic tok_add(logic [7:0] c);
    tok = {tok, c};
  endtask

  // receive side
  initial begin
    int gap;
    verdict_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req != hold_done) begin
        verdict_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done++;
      end else begin
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
          verdict_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        verdict_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (token_if.valid && token_if.ready) || (verdict_if.valid && verdict_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[number_literal_recognizer] ERROR");
      $finish;
    end
  end

  task automatic send_word(logic [7:0] c, logic e);
    int gap;
    token_if.valid <= 1'b1;
    token_if.data  <= '{ch: c, end_mark: e};
    @(posedge clk);
    while (!token_if.ready) @(posedge clk);
    words_sent++;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      token_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_token();
    foreach (tok[i]) send_word(tok[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
    tokens_sent++;
  endtask

  task automatic wait_for_flags();
    token_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    drains++;
  endtask

  task automatic build_number();
    if ($urandom_range(0, 3) == 0) tok_add(CH_MINUS);
    repeat ($urandom_range(0, 4)) tok_add(digit());
    if ($urandom_range(0, 2) != 0) begin
      tok_add(CH_POINT);
      repeat ($urandom_range(0, 3)) tok_add(digit());
      if ($urandom_range(0, 1) == 1) begin
        tok_add(CH_LO_E);
        if ($urandom_range(0, 4) != 0) tok_add($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        repeat ($urandom_range(0, 3)) tok_add(digit());
      end
    end
    if ($urandom_range(0, 3) == 0) tok_add(odd_bytes[$urandom_range(6, 11)]);
  endtask

  task automatic build_spelling();
    int k;
    k = $urandom_range(0, SPELL_COUNT - 1);
    for (int i = 0; i < SPELL_LEN[k]; i++) tok_add(SPELL_TEXT[k][i]);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) void'(tok.pop_back());
    if ($urandom_range(0, 4) == 0) tok.push_front($urandom_range(0, 1) ? digit() : CH_MINUS);
  endtask

  task automatic build_random_token();
    int kind;
    tok.delete();
    kind = $urandom_range(0, 99);
    if (kind < 55) build_number();
    else if (kind < 72) build_spelling();
    else if (kind < 86) repeat ($urandom_range(0, 6)) tok_add(8'($urandom_range(0, 255)));
    else repeat ($urandom_range(1, 6)) tok_add(odd_bytes[$urandom_range(0, 18)]);
    if (tok.size() > 0 && $urandom_range(0, 6) == 0)
      tok[$urandom_range(0, tok.size() - 1)] =
          $urandom_range(0, 1) ? CH_STOP : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) tok_add(odd_bytes[$urandom_range(0, 18)]);
  endtask

  initial begin
    string s;
    logic  held;
    rst <= 1'b1;
    token_if.valid <= 1'b0;
    token_if.data  <= '0;
    held = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    no_idle <= 1'b0;

    foreach (directed_tokens[n]) begin
      s = directed_tokens[n];
      tok.delete();
      for (int i = 0; i < s.len(); i++) tok_add(s[i]);
      send_token();
    end
    wait_for_flags();

    no_idle <= 1'b1;
    while (words_sent < WORD_TARGET) begin
      if (words_sent >= 300 && words_sent < 400) no_idle <= 1'b0;
      if (words_sent >= 400 && !held) begin
        hold_req <= hold_req + 1;
        held = 1'b1;
      end
      if (words_sent >= 650 && drains < 2) wait_for_flags();
      if (words_sent >= 780) no_idle <= 1'b1;
      else if (words_sent >= 400) no_idle <= 1'b0;
      build_random_token();
      send_token();
    end
    wait_for_flags();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d tokens (%0d directed) in %0d words; %0d flags checked, %0d numeric",
             tokens_sent, directed_tokens.size(), words_sent, flags_checked, numeric_seen);
    $display("receiver held off %0d time(s) for %0d cycles; sender drained %0d time(s)",
             hold_done, LONG_HOLD, drains);
    if (errors == 0)
      $display("[number_literal_recognizer] OK");
    else
      $display("[number_literal_recognizer] ERROR");
    $finish;
  end

endmodule
